@@ src/vfg_pkg.sv @@
// Shared constants, types and helper functions of the volume forward-gradient block.
package vfg_pkg;

   // Volume limits and sample precision.
   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLS    = 64;
   localparam int MAX_LEVELS  = 64;
   localparam int SAMPLE_BITS = 16;

   // Fixed field widths of the ports.
   localparam int COUNT_BITS     = 7;
   localparam int CSR_INDEX_BITS = 2;
   localparam int GRAD_BITS      = 23;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_COUNT   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COL_COUNT   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVEL_COUNT = 2'd2;

   // Widths of the position counters and the clamped counts.
   localparam int ROW_W = $clog2(MAX_ROWS + 1);
   localparam int COL_W = $clog2(MAX_COLS + 1);
   localparam int LVL_W = $clog2(MAX_LEVELS + 1);

   // Plane memory geometry.
   localparam int PLANE_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int SLOT_BITS   = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;
   localparam int RAM_DEPTH   = 1 << SLOT_BITS;

   // Arithmetic widths of the scaled differences.
   localparam int SCALE_W = (ROW_W > COL_W) ? ((ROW_W > LVL_W) ? ROW_W : LVL_W)
                                            : ((COL_W > LVL_W) ? COL_W : LVL_W);
   localparam int PROD_W  = SAMPLE_BITS + 1 + SCALE_W + 1;
   localparam int EXT_W   = (PROD_W > GRAD_BITS) ? PROD_W : GRAD_BITS;

   // Clamped geometry handed from the control to the arithmetic.
   typedef struct packed {
      logic [ROW_W-1:0] rows;
      logic [COL_W-1:0] cols;
      logic [LVL_W-1:0] levels;
   } vfg_geom_type;

   // One voxel issued for its gradient, with its boundary flags.
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic signed [SAMPLE_BITS-1:0] cur0;
      logic                          has_next;
      logic                          use_row;
      logic                          use_col;
      logic                          first;
      logic                          last;
   } vfg_issue_type;

   // A count of zero acts as one, a count above the limit acts as the limit.
   function automatic logic [ROW_W-1:0] clamp_rows(input logic [COUNT_BITS-1:0] v);
      logic [ROW_W-1:0] r;
      if (v == '0) begin
         r = ROW_W'(1);
      end else if (int'(v) > MAX_ROWS) begin
         r = ROW_W'(MAX_ROWS);
      end else begin
         r = ROW_W'(v);
      end
      return r;
   endfunction

   function automatic logic [COL_W-1:0] clamp_cols(input logic [COUNT_BITS-1:0] v);
      logic [COL_W-1:0] r;
      if (v == '0) begin
         r = COL_W'(1);
      end else if (int'(v) > MAX_COLS) begin
         r = COL_W'(MAX_COLS);
      end else begin
         r = COL_W'(v);
      end
      return r;
   endfunction

   function automatic logic [LVL_W-1:0] clamp_levels(input logic [COUNT_BITS-1:0] v);
      logic [LVL_W-1:0] r;
      if (v == '0) begin
         r = LVL_W'(1);
      end else if (int'(v) > MAX_LEVELS) begin
         r = LVL_W'(MAX_LEVELS);
      end else begin
         r = LVL_W'(v);
      end
      return r;
   endfunction

   // Saturate a scaled difference to the signed range of a gradient field.
   function automatic logic [GRAD_BITS-1:0] sat_grad(input logic signed [PROD_W-1:0] p);
      logic signed [EXT_W-1:0] x;
      logic signed [EXT_W-1:0] hi;
      logic signed [EXT_W-1:0] lo;
      logic signed [EXT_W-1:0] r;
      x  = EXT_W'(p);
      hi = signed'({{(EXT_W-GRAD_BITS+1){1'b0}}, {(GRAD_BITS-1){1'b1}}});
      lo = ~hi;
      if (x > hi) begin
         r = hi;
      end else if (x < lo) begin
         r = lo;
      end else begin
         r = x;
      end
      return r[GRAD_BITS-1:0];
   endfunction

endpackage

@@ src/volume_forward_gradient.sv @@
// Top level of the streaming three-dimensional forward-difference gradient.
//
// Voxels arrive in raster order (column fastest, then row, then level) and one plane
// is kept in a dual-read plane memory. A voxel's gradient word leaves once the voxel
// one plane later has arrived, or on a flush word while the last plane drains; a
// flush with nothing pending gives nothing. The block takes one word per clock
// sustained while the output is not stalled: each sample word costs one memory
// write, and each issued voxel costs two reads of the plane memory (right and lower
// neighbour). The word that releases a result is registered in the difference
// stage, and the result is then loaded into the output register, which drives
// rsp_valid, once that register is free or being emptied. The plane memory needs
// no clearing pass after reset. Count register writes restart the stream counters.
module volume_forward_gradient (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic signed [vfg_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [vfg_pkg::GRAD_BITS-1:0]  rsp_grad_row,
   output logic signed [vfg_pkg::GRAD_BITS-1:0]  rsp_grad_col,
   output logic signed [vfg_pkg::GRAD_BITS-1:0]  rsp_grad_level,
   output logic                                  rsp_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [vfg_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [vfg_pkg::COUNT_BITS-1:0]        csr_data
);
   import vfg_pkg::*;

   logic                   issue_valid;
   logic                   issue_ready;
   vfg_issue_type          issue;
   vfg_geom_type           geom;
   logic                   ram_wr_en;
   logic [SLOT_BITS-1:0]   ram_wr_addr;
   logic [SAMPLE_BITS-1:0] ram_wr_data;
   logic                   ram_rd_en;
   logic [SLOT_BITS-1:0]   ram_right_addr;
   logic [SLOT_BITS-1:0]   ram_below_addr;
   logic [SAMPLE_BITS-1:0] ram_right_data;
   logic [SAMPLE_BITS-1:0] ram_below_data;

   // Input words are taken whenever the difference stage can take an issue.
   assign req_ready = issue_ready;

   // Counters, configuration and memory addressing.
   vfg_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_kind       (req_kind),
      .req_sample     (req_sample),
      .issue_ready    (issue_ready),
      .issue_valid    (issue_valid),
      .issue          (issue),
      .geom           (geom),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_en      (ram_rd_en),
      .ram_right_addr (ram_right_addr),
      .ram_below_addr (ram_below_addr)
   );

   // Plane memory.
   vfg_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_plane_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_en     (ram_rd_en),
      .rd_a_addr (ram_right_addr),
      .rd_b_addr (ram_below_addr),
      .rd_a_data (ram_right_data),
      .rd_b_data (ram_below_data)
   );

   // Differences and output register.
   vfg_calc u_calc (
      .clock          (clock),
      .reset          (reset),
      .issue_valid    (issue_valid),
      .issue          (issue),
      .issue_ready    (issue_ready),
      .geom           (geom),
      .ram_right_data (ram_right_data),
      .ram_below_data (ram_below_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_grad_row   (rsp_grad_row),
      .rsp_grad_col   (rsp_grad_col),
      .rsp_grad_level (rsp_grad_level),
      .rsp_last       (rsp_last)
   );

endmodule

@@ src/vfg_ram.sv @@
// Generic simple dual-port RAM: one write port, two registered read ports.
module vfg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_data_ff;
   logic [WIDTH-1:0] rd_b_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Both read ports return the old contents and hold while not enabled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_data_ff <= mem_ff[rd_a_addr];
         rd_b_data_ff <= mem_ff[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule

@@ src/vfg_ctrl.sv @@
// Configuration registers, raster counters and plane memory addressing.
module vfg_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [vfg_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [vfg_pkg::COUNT_BITS-1:0]        csr_data,
   input  logic                                  req_valid,
   input  logic                                  req_kind,
   input  logic signed [vfg_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                  issue_ready,
   output logic                                  issue_valid,
   output vfg_pkg::vfg_issue_type                issue,
   output vfg_pkg::vfg_geom_type                 geom,
   output logic                                  ram_wr_en,
   output logic [vfg_pkg::SLOT_BITS-1:0]         ram_wr_addr,
   output logic [vfg_pkg::SAMPLE_BITS-1:0]       ram_wr_data,
   output logic                                  ram_rd_en,
   output logic [vfg_pkg::SLOT_BITS-1:0]         ram_right_addr,
   output logic [vfg_pkg::SLOT_BITS-1:0]         ram_below_addr
);
   import vfg_pkg::*;

   logic [COUNT_BITS-1:0]         row_count_ff, row_count_in;
   logic [COUNT_BITS-1:0]         col_count_ff, col_count_in;
   logic [COUNT_BITS-1:0]         level_count_ff, level_count_in;
   logic [COL_W-1:0]              in_col_ff, in_col_in;
   logic [ROW_W-1:0]              in_row_ff, in_row_in;
   logic [LVL_W-1:0]              in_level_ff, in_level_in;
   logic [SLOT_BITS-1:0]          in_slot_ff, in_slot_in;
   logic [COL_W-1:0]              out_col_ff, out_col_in;
   logic [ROW_W-1:0]              out_row_ff, out_row_in;
   logic [LVL_W-1:0]              out_level_ff, out_level_in;
   logic [SLOT_BITS-1:0]          out_slot_ff, out_slot_in;
   logic                          input_done_ff, input_done_in;
   logic signed [SAMPLE_BITS-1:0] slot0_ff, slot0_in;

   logic [ROW_W-1:0] rows;
   logic [COL_W-1:0] cols;
   logic [LVL_W-1:0] levels;
   logic             csr_write;
   logic             accept;
   logic             sample_path;
   logic             emit;
   logic             in_col_end;
   logic             in_row_end;
   logic             in_level_end;
   logic             out_col_end;
   logic             out_row_end;
   logic             out_level_end;
   logic             out_last;

   // Clamped geometry.
   assign rows   = clamp_rows(row_count_ff);
   assign cols   = clamp_cols(col_count_ff);
   assign levels = clamp_levels(level_count_ff);
   assign geom   = '{rows: rows, cols: cols, levels: levels};

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid;
   assign accept    = req_valid && issue_ready;

   // A sample after the volume is complete counts as a flush.
   assign sample_path = !req_kind && !input_done_ff;
   assign emit        = sample_path ? (in_level_ff != '0) : input_done_ff;

   assign in_col_end    = (in_col_ff + COL_W'(1)) == cols;
   assign in_row_end    = (in_row_ff + ROW_W'(1)) == rows;
   assign in_level_end  = (in_level_ff + LVL_W'(1)) == levels;
   assign out_col_end   = (out_col_ff + COL_W'(1)) == cols;
   assign out_row_end   = (out_row_ff + ROW_W'(1)) == rows;
   assign out_level_end = (out_level_ff + LVL_W'(1)) == levels;
   assign out_last      = input_done_ff && out_col_end && out_row_end && out_level_end;

   // Issue of the voxel at the output position.
   assign issue_valid = accept && emit;
   always_comb begin
      issue.sample   = req_sample;
      issue.cur0     = slot0_ff;
      issue.has_next = sample_path;
      issue.use_row  = !out_row_end;
      issue.use_col  = !out_col_end;
      issue.first    = (out_slot_ff == '0);
      issue.last     = out_last;
   end

   // Plane memory: the new sample overwrites its slot, the neighbours are read.
   assign ram_wr_en      = accept && sample_path;
   assign ram_wr_addr    = in_slot_ff;
   assign ram_wr_data    = req_sample;
   assign ram_rd_en      = issue_valid;
   assign ram_right_addr = out_slot_ff + SLOT_BITS'(1);
   assign ram_below_addr = out_slot_ff + SLOT_BITS'(cols);

   // Next state of the registers and counters.
   always_comb begin
      row_count_in   = row_count_ff;
      col_count_in   = col_count_ff;
      level_count_in = level_count_ff;
      in_col_in      = in_col_ff;
      in_row_in      = in_row_ff;
      in_level_in    = in_level_ff;
      in_slot_in     = in_slot_ff;
      out_col_in     = out_col_ff;
      out_row_in     = out_row_ff;
      out_level_in   = out_level_ff;
      out_slot_in    = out_slot_ff;
      input_done_in  = input_done_ff;
      slot0_in       = slot0_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_ROW_COUNT: begin
               row_count_in = csr_data;
            end
            CSR_COL_COUNT: begin
               col_count_in = csr_data;
            end
            CSR_LEVEL_COUNT: begin
               level_count_in = csr_data;
            end
            default: begin
            end
         endcase
         // A write to a listed register restarts the stream.
         if (csr_index == CSR_ROW_COUNT || csr_index == CSR_COL_COUNT ||
             csr_index == CSR_LEVEL_COUNT) begin
            in_col_in     = '0;
            in_row_in     = '0;
            in_level_in   = '0;
            in_slot_in    = '0;
            out_col_in    = '0;
            out_row_in    = '0;
            out_level_in  = '0;
            out_slot_in   = '0;
            input_done_in = 1'b0;
         end
      end else if (accept) begin
         // Input raster position.
         if (sample_path) begin
            if (in_slot_ff == '0) begin
               slot0_in = req_sample;
            end
            if (in_col_end) begin
               in_col_in = '0;
               if (in_row_end) begin
                  in_row_in  = '0;
                  in_slot_in = '0;
                  if (in_level_end) begin
                     in_level_in   = '0;
                     input_done_in = 1'b1;
                  end else begin
                     in_level_in = in_level_ff + LVL_W'(1);
                  end
               end else begin
                  in_row_in  = in_row_ff + ROW_W'(1);
                  in_slot_in = in_slot_ff + SLOT_BITS'(1);
               end
            end else begin
               in_col_in  = in_col_ff + COL_W'(1);
               in_slot_in = in_slot_ff + SLOT_BITS'(1);
            end
         end
         // Output raster position; the final voxel restarts the stream.
         if (emit) begin
            if (out_last) begin
               in_col_in     = '0;
               in_row_in     = '0;
               in_level_in   = '0;
               in_slot_in    = '0;
               out_col_in    = '0;
               out_row_in    = '0;
               out_level_in  = '0;
               out_slot_in   = '0;
               input_done_in = 1'b0;
            end else if (out_col_end) begin
               out_col_in = '0;
               if (out_row_end) begin
                  out_row_in   = '0;
                  out_slot_in  = '0;
                  out_level_in = out_level_ff + LVL_W'(1);
               end else begin
                  out_row_in  = out_row_ff + ROW_W'(1);
                  out_slot_in = out_slot_ff + SLOT_BITS'(1);
               end
            end else begin
               out_col_in  = out_col_ff + COL_W'(1);
               out_slot_in = out_slot_ff + SLOT_BITS'(1);
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff   <= COUNT_BITS'(64);
         col_count_ff   <= COUNT_BITS'(64);
         level_count_ff <= COUNT_BITS'(16);
         in_col_ff      <= '0;
         in_row_ff      <= '0;
         in_level_ff    <= '0;
         in_slot_ff     <= '0;
         out_col_ff     <= '0;
         out_row_ff     <= '0;
         out_level_ff   <= '0;
         out_slot_ff    <= '0;
         input_done_ff  <= 1'b0;
      end else begin
         row_count_ff   <= row_count_in;
         col_count_ff   <= col_count_in;
         level_count_ff <= level_count_in;
         in_col_ff      <= in_col_in;
         in_row_ff      <= in_row_in;
         in_level_ff    <= in_level_in;
         in_slot_ff     <= in_slot_in;
         out_col_ff     <= out_col_in;
         out_row_ff     <= out_row_in;
         out_level_ff   <= out_level_in;
         out_slot_ff    <= out_slot_in;
         input_done_ff  <= input_done_in;
      end
   end

   // Copy of the sample held in slot zero, which no neighbour read supplies.
   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
   end

endmodule

@@ src/vfg_calc.sv @@
// Difference stage and output register of the volume forward-gradient block.
module vfg_calc (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  issue_valid,
   input  vfg_pkg::vfg_issue_type                issue,
   output logic                                  issue_ready,
   input  vfg_pkg::vfg_geom_type                 geom,
   input  logic [vfg_pkg::SAMPLE_BITS-1:0]       ram_right_data,
   input  logic [vfg_pkg::SAMPLE_BITS-1:0]       ram_below_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [vfg_pkg::GRAD_BITS-1:0]  rsp_grad_row,
   output logic signed [vfg_pkg::GRAD_BITS-1:0]  rsp_grad_col,
   output logic signed [vfg_pkg::GRAD_BITS-1:0]  rsp_grad_level,
   output logic                                  rsp_last
);
   import vfg_pkg::*;

   logic                          p1_valid_ff, p1_valid_in;
   vfg_issue_type                 p1_ff, p1_in;
   logic signed [SAMPLE_BITS-1:0] prev_right_ff, prev_right_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [GRAD_BITS-1:0]          grad_row_ff, grad_row_in;
   logic [GRAD_BITS-1:0]          grad_col_ff, grad_col_in;
   logic [GRAD_BITS-1:0]          grad_level_ff, grad_level_in;
   logic                          last_ff, last_in;

   logic                          p1_go;
   logic signed [SAMPLE_BITS-1:0] cur;
   logic signed [PROD_W-1:0]      cur_ext;
   logic signed [PROD_W-1:0]      row_diff;
   logic signed [PROD_W-1:0]      col_diff;
   logic signed [PROD_W-1:0]      level_diff;
   logic signed [PROD_W-1:0]      row_prod;
   logic signed [PROD_W-1:0]      col_prod;
   logic signed [PROD_W-1:0]      level_prod;

   // The stage moves on when the output register is free or being emptied.
   assign p1_go       = p1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign issue_ready = !p1_valid_ff || p1_go;

   // Current voxel: the prior voxel's right read, or slot zero's copy.
   assign cur     = p1_ff.first ? p1_ff.cur0 : prev_right_ff;
   assign cur_ext = PROD_W'(cur);

   // Forward differences, scaled by the size of their dimension.
   always_comb begin
      row_diff   = PROD_W'(signed'(ram_below_data)) - cur_ext;
      col_diff   = PROD_W'(signed'(ram_right_data)) - cur_ext;
      level_diff = PROD_W'(p1_ff.sample) - cur_ext;
      row_prod   = row_diff * signed'(PROD_W'(geom.rows));
      col_prod   = col_diff * signed'(PROD_W'(geom.cols));
      level_prod = level_diff * signed'(PROD_W'(geom.levels));
   end

   // Next state of the stage and the output register.
   always_comb begin
      p1_valid_in   = p1_valid_ff;
      p1_in         = p1_ff;
      prev_right_in = prev_right_ff;
      rsp_valid_in  = rsp_valid_ff;
      grad_row_in   = grad_row_ff;
      grad_col_in   = grad_col_ff;
      grad_level_in = grad_level_ff;
      last_in       = last_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (p1_go) begin
         p1_valid_in   = 1'b0;
         prev_right_in = signed'(ram_right_data);
         rsp_valid_in  = 1'b1;
         grad_row_in   = p1_ff.use_row ? sat_grad(row_prod) : '0;
         grad_col_in   = p1_ff.use_col ? sat_grad(col_prod) : '0;
         grad_level_in = p1_ff.has_next ? sat_grad(level_prod) : '0;
         last_in       = p1_ff.last;
      end
      if (issue_valid) begin
         p1_valid_in = 1'b1;
         p1_in       = issue;
      end
   end

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      p1_ff         <= p1_in;
      prev_right_ff <= prev_right_in;
      grad_row_ff   <= grad_row_in;
      grad_col_ff   <= grad_col_in;
      grad_level_ff <= grad_level_in;
      last_ff       <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_grad_row   = signed'(grad_row_ff);
   assign rsp_grad_col   = signed'(grad_col_ff);
   assign rsp_grad_level = signed'(grad_level_ff);
   assign rsp_last       = last_ff;

endmodule
